@@ hdl/imu_dfr_pkg.sv @@
// Package: constants and types shared by the IMU frame deframer.
package imu_dfr_pkg;

    localparam int FIELD_COUNT = 9;
    localparam int MAX_VALUES  = 9;
    localparam int FIELD_BYTES = 2 * FIELD_COUNT;
    localparam int IDX_W       = $clog2(FIELD_BYTES);

    localparam logic [7:0] HDR0     = 8'hA5;
    localparam logic [7:0] HDR1     = 8'h5A;
    localparam logic [7:0] TAIL     = 8'hAA;
    localparam logic [7:0] MIN_LEN  = 8'd2;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_CSUM   = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_PRE  = 3'b010,
        PH_RECV = 3'b100
    } phase_t;

    typedef logic signed [15:0] sample_t;

    typedef struct packed {
        logic                         status;
        logic [7:0]                   frame_length;
        sample_t [MAX_VALUES-1:0]     values;
    } result_t;

endpackage

@@ hdl/imu_dfr_parser.sv @@
// Frame parser: header hunt, length/checksum tracking and field byte capture.
module imu_dfr_parser
    import imu_dfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res,
    output phase_t     phase
);

    phase_t     phase_reg, phase_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] chk_reg, chk_next;
    logic [7:0] field_reg  [FIELD_BYTES];
    logic [7:0] field_next [FIELD_BYTES];
    logic [7:0] idx;

    assign idx   = pos_reg - 8'd1;
    assign phase = phase_reg;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        chk_next   = chk_reg;
        field_next = field_reg;
        res_valid  = 1'b0;
        if (byte_valid) begin
            case (phase_reg)
                PH_RECV: begin
                    if (pos_reg == 8'd0) begin
                        len_next = rx_byte;
                        sum_next = rx_byte;
                        if (rx_byte < MIN_LEN) begin
                            phase_next = PH_HUNT;
                        end else begin
                            pos_next = 8'd1;
                        end
                    end else if (pos_reg == len_reg) begin
                        res_valid  = (rx_byte == TAIL);
                        phase_next = PH_HUNT;
                        pos_next   = 8'd0;
                    end else if (pos_reg == len_reg - 8'd1) begin
                        chk_next = rx_byte;
                        pos_next = pos_reg + 8'd1;
                    end else begin
                        if (idx < 8'(FIELD_BYTES)) begin
                            field_next[idx[IDX_W-1:0]] = rx_byte;
                        end
                        sum_next = sum_reg + rx_byte;
                        pos_next = pos_reg + 8'd1;
                    end
                end
                default: begin
                    pos_next = 8'd0;
                    if (rx_byte == HDR0) begin
                        phase_next = PH_PRE;
                    end else if (phase_reg == PH_PRE && rx_byte == HDR1) begin
                        phase_next = PH_RECV;
                        sum_next   = 8'd0;
                        chk_next   = 8'd0;
                        for (int i = 0; i < FIELD_BYTES; i++) begin
                            field_next[i] = 8'd0;
                        end
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        res.status       = (sum_reg != chk_reg) ? STATUS_CSUM : STATUS_OK;
        res.frame_length = len_reg;
        res.values       = '0;
        for (int k = 0; k < FIELD_COUNT; k++) begin
            res.values[k] = {field_reg[2*k], field_reg[2*k+1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pos_reg   <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg   <= len_next;
        sum_reg   <= sum_next;
        chk_reg   <= chk_next;
        field_reg <= field_next;
    end

endmodule

@@ hdl/imu_dfr_out_reg.sv @@
// Result register: holds one finished frame result until it is taken.
module imu_dfr_out_reg
    import imu_dfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    input  result_t res,
    output logic    in_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign in_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

endmodule

@@ hdl/imu_frame_deframer.sv @@
// Top level of the IMU frame deframer.
//
//  channel | direction | ports                         | contents
//  s_      | in        | s_valid s_ready s_rx_byte     | one received link byte
//  m_      | out       | m_valid m_ready m_status ...  | one decoded frame
//
// One byte is taken per cycle while s_ready is high; the parser state updates at the transfer.
// A frame result appears on m_ in the cycle after the transfer of its tail byte.
// s_ready is low only while a result waits and m_ready is low.
// aresetn (synchronous) returns the parser to header hunt and empties m_.
module imu_frame_deframer
    import imu_dfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_status,
    output logic [7:0] m_frame_length,
    output sample_t    m_yaw_raw,
    output sample_t    m_pitch_raw,
    output sample_t    m_roll_raw,
    output sample_t    m_accel_x,
    output sample_t    m_accel_y,
    output sample_t    m_accel_z,
    output sample_t    m_rate_x,
    output sample_t    m_rate_y,
    output sample_t    m_rate_z
);

    logic    s_xfer;
    logic    res_valid;
    result_t res;
    result_t m_res;
    phase_t  phase;

    assign s_xfer = s_valid && s_ready;

    imu_dfr_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_xfer),
        .rx_byte    (s_rx_byte),
        .res_valid  (res_valid),
        .res        (res),
        .phase      (phase)
    );

    imu_dfr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_status       = m_res.status;
    assign m_frame_length = m_res.frame_length;
    assign m_yaw_raw      = m_res.values[0];
    assign m_pitch_raw    = m_res.values[1];
    assign m_roll_raw     = m_res.values[2];
    assign m_accel_x      = m_res.values[3];
    assign m_accel_y      = m_res.values[4];
    assign m_accel_z      = m_res.values[5];
    assign m_rate_x       = m_res.values[6];
    assign m_rate_y       = m_res.values[7];
    assign m_rate_z       = m_res.values[8];

`ifndef ASSERT_OFF
    a_result_after_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_xfer && s_rx_byte == TAIL && phase == PH_RECV))
        else $error("result without a tail transfer");

    a_header_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && phase != PH_RECV && s_rx_byte == HDR0) |=> (phase == PH_PRE))
        else $error("header byte did not start a frame hunt");

    a_length_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_length >= MIN_LEN))
        else $error("result with a frame length below two");

    a_no_result_outside_recv: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (phase == PH_RECV))
        else $error("result raised outside frame reception");
`endif

endmodule

@@ verif/tb_imu_frame_deframer.sv @@
// Testbench for the IMU frame deframer: byte streams checked against a frame predictor.
module tb_imu_frame_deframer;
    import imu_dfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 250;
    localparam int RANDOM_BYTES  = 320;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_status;
    logic [7:0] m_frame_length;
    sample_t    m_yaw_raw, m_pitch_raw, m_roll_raw;
    sample_t    m_accel_x, m_accel_y, m_accel_z;
    sample_t    m_rate_x, m_rate_y, m_rate_z;

    imu_frame_deframer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_frame_length (m_frame_length),
        .m_yaw_raw      (m_yaw_raw),
        .m_pitch_raw    (m_pitch_raw),
        .m_roll_raw     (m_roll_raw),
        .m_accel_x      (m_accel_x),
        .m_accel_y      (m_accel_y),
        .m_accel_z      (m_accel_z),
        .m_rate_x       (m_rate_x),
        .m_rate_y       (m_rate_y),
        .m_rate_z       (m_rate_z)
    );

    // predictor state
    phase_t     link_phase = PH_HUNT;
    logic [7:0] link_pos = '0;
    logic [7:0] link_len = '0;
    logic [7:0] link_sum = '0;
    logic [7:0] link_csum = '0;
    logic [7:0] link_fields [FIELD_BYTES];

    result_t    frames_due [$];
    int         bytes_sent = 0;
    int         mismatches = 0;
    bit         quiet = 1'b0;
    bit         hold_off_req = 1'b0;

    string value_name [MAX_VALUES] = '{"yaw_raw", "pitch_raw", "roll_raw", "accel_x",
                                       "accel_y", "accel_z", "rate_x", "rate_y", "rate_z"};

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb_imu_frame_deframer: FAIL");
        $finish;
    end

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] corner [8] = '{8'h00, 8'hFF, 8'h7F, 8'h80, HDR0, HDR1, TAIL, 8'h01};
        if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void clear_fields();
        foreach (link_fields[i]) link_fields[i] = '0;
    endfunction

    // advance the frame parser by one link byte; queue a frame when a correct tail byte arrives
    function automatic void track_link_byte(logic [7:0] b);
        result_t frame;
        if (link_phase == PH_RECV) begin
            if (link_pos == 0) begin
                link_len = b;
                link_sum = b;
                if (b < MIN_LEN) begin
                    link_phase = PH_HUNT;
                    link_pos   = '0;
                end else begin
                    link_pos = 8'd1;
                end
            end else if (link_pos == link_len) begin
                if (b == TAIL) begin
                    frame.status       = (link_sum != link_csum) ? STATUS_CSUM : STATUS_OK;
                    frame.frame_length = link_len;
                    for (int k = 0; k < MAX_VALUES; k++)
                        frame.values[k] = (k < FIELD_COUNT) ?
                            {link_fields[2*k], link_fields[2*k+1]} : '0;
                    frames_due.push_back(frame);
                end
                link_phase = PH_HUNT;
                link_pos   = '0;
            end else if (link_pos == link_len - 8'd1) begin
                link_csum = b;
                link_pos  = link_pos + 8'd1;
            end else begin
                if (int'(link_pos) - 1 < FIELD_BYTES) link_fields[link_pos - 8'd1] = b;
                link_sum = link_sum + b;
                link_pos = link_pos + 8'd1;
            end
        end else if (b == HDR0) begin
            link_phase = PH_PRE;
            link_pos   = '0;
        end else if (link_phase == PH_PRE && b == HDR1) begin
            link_phase = PH_RECV;
            link_pos   = '0;
            link_sum   = '0;
            link_csum  = '0;
            clear_fields();
        end else begin
            link_phase = PH_HUNT;
            link_pos   = '0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
        int gap = quiet ? 0 : gap_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid   <= 1'b0;
            s_rx_byte <= 8'($urandom_range(0, 255));
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        track_link_byte(b);
        if (counted) bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] payload [$],
                              input bit bad_sum, input bit bad_tail, input bit double_hdr);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] t;
        if (double_hdr) send_byte(HDR0);
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(len);
        if (len < MIN_LEN) return;
        sum = len;
        for (int i = 0; i < int'(len) - 2; i++) begin
            b = (i < payload.size()) ? payload[i] : pick_byte();
            sum += b;
            send_byte(b);
        end
        if (bad_sum) sum ^= 8'($urandom_range(1, 255));
        send_byte(sum);
        t = TAIL;
        if (bad_tail) begin
            do t = pick_byte(); while (t == TAIL);
        end
        send_byte(t);
    endtask

    task automatic send_random_frame();
        logic [7:0] none [$];
        logic [7:0] len;
        int r = $urandom_range(0, 99);
        if (r < 5)       len = 8'($urandom_range(0, 1));
        else if (r < 30) len = 8'd20;
        else if (r < 80) len = 8'($urandom_range(2, 22));
        else if (r < 97) len = 8'($urandom_range(23, 40));
        else             len = 8'($urandom_range(41, 120));
        send_frame(len, none, $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0,
                   $urandom_range(0, 9) == 0);
    endtask

    // header restarts, stray bytes, minimum and short lengths, bad checksum, bad tail
    task automatic test_directed();
        logic [7:0] seq [25] = '{HDR0, HDR0, HDR1, 8'h02, 8'h02, TAIL,
                                 HDR0, 8'h00, HDR1,
                                 HDR0, HDR1, 8'h01,
                                 HDR0, HDR1, 8'h04, 8'h80, 8'h00, 8'h00, TAIL,
                                 HDR0, HDR1, 8'h03, 8'hFF, 8'h02, 8'h55};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_extreme_values();
        logic [7:0] pl [$] = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                               8'h00, 8'h01, HDR0, TAIL, HDR1, HDR0, 8'h80, 8'h01,
                               8'hFE, 8'hFF};
        send_frame(8'd20, pl, 1'b0, 1'b0, 1'b0);
        pl = '{8'h7F, 8'hFF, 8'h80, 8'h00};
        send_frame(8'd21, pl, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_longest_frame();
        logic [7:0] none [$];
        send_frame(8'd255, none, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_random_stream();
        int stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 4)) send_byte(pick_byte(), 1'b0);
            send_random_frame();
        end
        quiet = 1'b0;
    endtask

    // result side held off while frames keep coming back to back
    task automatic test_backpressure();
        logic [7:0] none [$];
        hold_off_req = 1'b1;
        quiet = 1'b1;
        repeat (6) send_frame(8'($urandom_range(2, 8)), none, 1'b0, 1'b0, 1'b0);
        quiet = 1'b0;
    endtask

    initial begin : result_side
        int stall;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                stall = gap_len() + 1;
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : frame_check
        result_t want;
        sample_t got [MAX_VALUES];
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                $error("result transfer with no frame expected");
                mismatches++;
            end else begin
                want = frames_due.pop_front();
                got  = '{m_yaw_raw, m_pitch_raw, m_roll_raw, m_accel_x, m_accel_y,
                         m_accel_z, m_rate_x, m_rate_y, m_rate_z};
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    mismatches++;
                end
                if (m_frame_length !== want.frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           want.frame_length, m_frame_length);
                    mismatches++;
                end
                for (int k = 0; k < MAX_VALUES; k++) begin
                    if (got[k] !== want.values[k]) begin
                        $error("%s: expected %0d, got %0d",
                               value_name[k], want.values[k], got[k]);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        clear_fields();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_extreme_values();
        test_backpressure();
        test_longest_frame();
        test_random_stream();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("tb_imu_frame_deframer: PASS");
        end else begin
            $display("tb_imu_frame_deframer: FAIL");
        end
        $finish;
    end

endmodule
